/* design/assert_macros.svh */
// Assertion macros used by the sequencer top-level module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define FMS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sequencer check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define FMS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sequencer check failed");

`endif

/* design/fms_pkg.sv */
package fms_pkg;

  localparam logic [3:0] ST_OFF     = 4'd0;
  localparam logic [3:0] ST_WAIT    = 4'd1;
  localparam logic [3:0] ST_GUIDED  = 4'd2;
  localparam logic [3:0] ST_ARMING  = 4'd3;
  localparam logic [3:0] ST_TAKEOFF = 4'd4;
  localparam logic [3:0] ST_CLIMB   = 4'd5;
  localparam logic [3:0] ST_HOVER   = 4'd6;
  localparam logic [3:0] ST_RUN     = 4'd7;
  localparam logic [3:0] ST_HOME    = 4'd8;
  localparam logic [3:0] ST_FREE    = 4'd9;
  localparam logic [3:0] ST_LAND    = 4'd10;

  localparam logic [2:0] REQ_OFF   = 3'd0;
  localparam logic [2:0] REQ_HOVER = 3'd1;
  localparam logic [2:0] REQ_RUN   = 3'd2;
  localparam logic [2:0] REQ_HOME  = 3'd3;
  localparam logic [2:0] REQ_FREE  = 3'd4;

  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_COMMAND = 1'b1;

  localparam logic [1:0] SP_NONE   = 2'd0;
  localparam logic [1:0] SP_HOVER  = 2'd1;
  localparam logic [1:0] SP_HOME   = 2'd2;
  localparam logic [1:0] SP_POLICY = 2'd3;

  localparam logic CFG_TARGET    = 1'b0;
  localparam logic CFG_TOLERANCE = 1'b1;

  // Timeouts in 20 ms ticks; a timeout fires when the count exceeds them.
  localparam logic [7:0] T_DISARM_RETRY = 8'd75;
  localparam logic [7:0] T_RETRY        = 8'd100;
  localparam logic [7:0] T_CLIMB_RETRY  = 8'd125;
  localparam logic [7:0] T_LAND_RETRY   = 8'd150;

  localparam logic signed [15:0] ALT_GROUND_BAND = 16'sd250;
  localparam logic signed [15:0] ALT_TOUCHDOWN   = 16'sd200;
  localparam logic signed [16:0] AGL_LOW         = 17'sd200;
  localparam logic signed [16:0] AGL_STALLED     = 17'sd150;

  localparam logic [14:0] TARGET_RESET    = 15'd1000;
  localparam logic [9:0]  TOLERANCE_RESET = 10'd50;

  typedef struct packed {
    logic        operation;
    logic [2:0]  requested_state;
    logic        armed;
    logic        connected;
    logic        mode_guided;
    logic        mode_land;
    logic signed [15:0] altitude_mm;
    logic        home_known;
    logic        gates_cleared;
  } fms_in_t;

  typedef struct packed {
    logic [3:0]  mode;
    logic signed [15:0] ground_level_mm;
    logic        ground_level_valid;
    logic [7:0]  ticks_since_request;
    logic [7:0]  ticks_since_run_start;
  } fms_state_t;

  typedef struct packed {
    logic [3:0]  mode_state;
    logic        accepted;
    logic        req_force_disarm;
    logic        req_force_arm;
    logic        req_arm;
    logic        req_set_guided;
    logic        req_land;
    logic        req_takeoff;
    logic        policy_restart;
    logic [1:0]  setpoint_kind;
    logic signed [15:0] setpoint_z_mm;
  } fms_res_t;

endpackage

/* design/flight_mode_sequencer.sv */
// A request accepted into the input register is loaded into the result register
// when it moves on, and its result is then offered on the master side.
// Throughput: one request per cycle, sustained, while the result side keeps
// up.
// Reset (rst, synchronous, active high) returns to OFF, clears both tick counters
// and the ground capture, sets the height registers to 1000 mm and 50 mm and
// empties both registers; no clearing pass is needed.
module flight_mode_sequencer import fms_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // Slave side.
  input  logic        s_tvalid,
  output logic        s_tready,
  // s_tdata, from bit 0: requested_state[2:0], armed, connected, mode_guided,
  // mode_land, altitude_mm[15:0], home_known, gates_cleared, zero fill.
  input  logic [31:0] s_tdata,
  // s_tuser: operation (0 tick, 1 operator command).
  input  logic        s_tuser,
  // Master side.
  output logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata, from bit 0: mode_state[3:0], accepted, req_force_disarm,
  // req_force_arm, req_arm, req_set_guided, req_land, req_takeoff,
  // policy_restart, setpoint_z_mm[15:0], zero fill.
  output logic [31:0] m_tdata,
  // m_tuser: setpoint_kind[1:0].
  output logic [1:0]  m_tuser,
  // Configuration writes: index 0 target altitude, index 1 tolerance.
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [14:0] cfg_data
);

`include "assert_macros.svh"

  // Configuration registers.
  logic [14:0] target_altitude_mm;
  logic [9:0]  altitude_tolerance_mm;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_altitude_mm <= TARGET_RESET;
      altitude_tolerance_mm <= TOLERANCE_RESET;
    end else if (cfg_we) begin
      if (cfg_addr == CFG_TARGET) begin
        target_altitude_mm <= cfg_data;
      end else begin
        altitude_tolerance_mm <= cfg_data[9:0];
      end
    end
  end

  // Input register. A request moves on to the result register whenever that
  // register is empty or being drained, and the sequencer state is updated
  // on that same edge, so requests are applied strictly in arrival order.
  fms_in_t    in_item;
  logic       in_valid;
  fms_state_t state;
  fms_state_t state_next;
  fms_res_t   res_next;
  fms_res_t   res;
  logic       out_valid;
  logic       advance;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.operation       <= s_tuser;
      in_item.requested_state <= s_tdata[2:0];
      in_item.armed           <= s_tdata[3];
      in_item.connected       <= s_tdata[4];
      in_item.mode_guided     <= s_tdata[5];
      in_item.mode_land       <= s_tdata[6];
      in_item.altitude_mm     <= s_tdata[22:7];
      in_item.home_known      <= s_tdata[23];
      in_item.gates_cleared   <= s_tdata[24];
    end
  end

  // One step of the sequence: all of it is short logic between the two
  // registers.
  fms_core u_core (
    .item                  (in_item),
    .cur                   (state),
    .target_altitude_mm    (target_altitude_mm),
    .altitude_tolerance_mm (altitude_tolerance_mm),
    .nxt                   (state_next),
    .res                   (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = res.setpoint_kind;
  assign m_tdata  = {4'd0, res.setpoint_z_mm, res.policy_restart, res.req_takeoff,
                     res.req_land, res.req_set_guided, res.req_arm, res.req_force_arm,
                     res.req_force_disarm, res.accepted, res.mode_state};

  // The state never leaves the defined set of eleven codes.
  `FMS_ASSERT_NOW(a_mode_range, 1'b1, state.mode <= ST_LAND)
  // Once a ground altitude is captured it is kept until reset.
  `FMS_ASSERT_NOW(a_ground_sticky, 1'b1, !$fell(state.ground_level_valid))
  // A request that moves on always leaves a result behind.
  `FMS_ASSERT_NEXT(a_advance_fills, advance, out_valid)
  // A forced arm is only issued while climbing; the same tick may already
  // reach hover height.
  `FMS_ASSERT_NOW(a_force_arm_climb, out_valid && res.req_force_arm,
                  res.mode_state == ST_CLIMB || res.mode_state == ST_HOVER)
  // The result mirrors the state it left behind.
  `FMS_ASSERT_NEXT(a_result_state, advance, res.mode_state == state.mode)

endmodule

/* design/fms_core.sv */
module fms_core import fms_pkg::*; (
  input  fms_in_t    item,
  input  fms_state_t cur,
  input  logic [14:0] target_altitude_mm,
  input  logic [9:0]  altitude_tolerance_mm,
  output fms_state_t nxt,
  output fms_res_t   res
);

  logic               airborne;
  logic               near_ground;
  logic signed [15:0] gz;
  logic signed [16:0] agl;
  logic signed [16:0] hover_sum;
  logic signed [15:0] tlz;
  logic signed [15:0] reach_lim;
  logic [7:0]         treq;
  logic [7:0]         trun;

  assign airborne = cur.mode inside {ST_HOVER, ST_RUN, ST_HOME, ST_FREE, ST_CLIMB, ST_TAKEOFF};
  assign near_ground = !item.armed || (item.altitude_mm < ALT_GROUND_BAND);
  assign treq = (cur.ticks_since_request == 8'hFF) ? 8'hFF : cur.ticks_since_request + 8'd1;
  assign trun = (cur.ticks_since_run_start == 8'hFF) ? 8'hFF : cur.ticks_since_run_start + 8'd1;

  // Ground is captured on this same tick while disarmed in the early states.
  always_comb begin
    if (!item.armed && cur.mode <= ST_ARMING) begin
      gz = item.altitude_mm;
    end else if (cur.ground_level_valid) begin
      gz = cur.ground_level_mm;
    end else begin
      gz = 16'sd0;
    end
  end

  assign agl       = {item.altitude_mm[15], item.altitude_mm} - {gz[15], gz};
  assign hover_sum = {gz[15], gz} + $signed({2'b00, target_altitude_mm});
  assign tlz       = (hover_sum > 17'sd32767) ? 16'sh7FFF : hover_sum[15:0];
  assign reach_lim = $signed({1'b0, target_altitude_mm}) - $signed({6'd0, altitude_tolerance_mm});

  always_comb begin
    nxt = cur;
    res = '0;
    res.accepted = 1'b1;
    if (item.operation == OP_COMMAND) begin
      case (item.requested_state)
        REQ_OFF: begin
          if (!near_ground && airborne) begin
            nxt.mode = ST_LAND;
            res.req_land = 1'b1;
          end else begin
            nxt.mode = ST_OFF;
            res.req_force_disarm = item.armed;
          end
        end
        REQ_HOVER: begin
          if (cur.mode == ST_OFF || cur.mode == ST_LAND) begin
            nxt.mode = ST_WAIT;
          end else begin
            res.req_set_guided = !item.mode_guided;
            nxt.mode = ST_HOVER;
          end
        end
        REQ_RUN: begin
          if (cur.mode == ST_OFF || cur.mode == ST_LAND) begin
            res.accepted = 1'b0;
          end else begin
            if (cur.mode inside {ST_HOVER, ST_HOME, ST_FREE}) begin
              res.req_set_guided = !item.mode_guided;
            end
            res.policy_restart = 1'b1;
            nxt.ticks_since_run_start = 8'd0;
            nxt.mode = ST_RUN;
          end
        end
        REQ_HOME: begin
          if (!item.home_known || cur.mode == ST_OFF || cur.mode == ST_LAND) begin
            res.accepted = 1'b0;
          end else begin
            res.req_set_guided = !item.mode_guided;
            nxt.mode = ST_HOME;
          end
        end
        REQ_FREE: begin
          nxt.mode = ST_FREE;
        end
        default: begin
          res.accepted = 1'b0;
        end
      endcase
    end else begin
      nxt.ticks_since_request = treq;
      nxt.ticks_since_run_start = trun;
      if (!item.armed && cur.mode <= ST_ARMING) begin
        nxt.ground_level_mm = item.altitude_mm;
        nxt.ground_level_valid = 1'b1;
      end
      case (cur.mode)
        ST_OFF: begin
          if (item.armed && treq > T_DISARM_RETRY) begin
            res.req_force_disarm = 1'b1;
            nxt.ticks_since_request = 8'd0;
          end
        end
        ST_WAIT: begin
          if (item.connected) begin
            nxt.mode = ST_GUIDED;
            nxt.ticks_since_request = 8'd0;
          end
        end
        ST_GUIDED: begin
          if (item.mode_guided) begin
            nxt.mode = ST_ARMING;
          end else if (treq > T_RETRY) begin
            res.req_set_guided = 1'b1;
            nxt.ticks_since_request = 8'd0;
          end
        end
        ST_ARMING: begin
          if (item.armed) begin
            nxt.mode = ST_TAKEOFF;
          end else if (treq > T_RETRY) begin
            res.req_arm = 1'b1;
            nxt.ticks_since_request = 8'd0;
          end
        end
        ST_TAKEOFF: begin
          if (treq > T_RETRY) begin
            res.req_takeoff = 1'b1;
            nxt.mode = ST_CLIMB;
            nxt.ticks_since_request = 8'd0;
          end
        end
        ST_CLIMB: begin
          if (agl < AGL_STALLED && treq > T_CLIMB_RETRY) begin
            res.req_force_arm = !item.armed;
            res.req_set_guided = !item.mode_guided;
            res.req_takeoff = 1'b1;
            nxt.ticks_since_request = 8'd0;
          end else if (agl >= AGL_LOW) begin
            res.setpoint_kind = SP_HOVER;
            res.setpoint_z_mm = tlz;
          end
          if (agl >= $signed({reach_lim[15], reach_lim})) begin
            nxt.mode = ST_HOVER;
          end
        end
        ST_HOVER: begin
          if (agl < AGL_LOW) begin
            nxt.mode = ST_OFF;
            res.req_force_disarm = 1'b1;
          end else begin
            res.setpoint_kind = SP_HOVER;
            res.setpoint_z_mm = tlz;
          end
        end
        ST_RUN: begin
          if (agl < AGL_LOW && trun > T_RETRY) begin
            nxt.mode = ST_OFF;
            res.req_force_disarm = 1'b1;
          end else if (item.gates_cleared) begin
            nxt.mode = ST_HOVER;
            res.setpoint_kind = SP_HOVER;
            res.setpoint_z_mm = item.altitude_mm;
          end else begin
            res.setpoint_kind = SP_POLICY;
          end
        end
        ST_HOME: begin
          if (agl < AGL_LOW) begin
            nxt.mode = ST_OFF;
            res.req_force_disarm = 1'b1;
          end else begin
            if (!item.mode_guided && treq > T_RETRY) begin
              res.req_set_guided = 1'b1;
              nxt.ticks_since_request = 8'd0;
            end
            res.setpoint_kind = SP_HOME;
          end
        end
        ST_LAND: begin
          if (treq > T_LAND_RETRY && !item.mode_land) begin
            res.req_land = 1'b1;
            nxt.ticks_since_request = 8'd0;
          end
          if (!item.armed || item.altitude_mm <= ALT_TOUCHDOWN) begin
            res.req_force_disarm = item.armed;
            nxt.mode = ST_OFF;
          end
        end
        default: begin
        end
      endcase
    end
    res.mode_state = nxt.mode;
  end

endmodule
